// ===== sv/assert_macros.svh =====
// Assertion macros used by the matrix unit RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check of a property, sampled on clk, off while reset is low.
`define EST_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// Same check written as an antecedent and a consequent in the same cycle.
`define EST_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

// ===== sv/est_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// est_pkg
// Constants for the Euler angle scale transform matrix unit.
// ----------------------------------------------------------------------------
package est_pkg;

    localparam int ANGLE_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;

    localparam logic [15:0] FACTOR_RST = 16'd256;

    localparam logic [30:0] Q30_ONE = 31'h4000_0000;

    // odd Taylor series of a quarter-turn sine, Q30
    localparam logic signed [33:0] SIN_COEF [0:5] = '{
        34'sd1686629713, 34'sd693598670, 34'sd85569306,
        34'sd5026995,    34'sd172271,    34'sd3864
    };

    localparam logic [1:0] ROW_LAST = 2'd3;

    typedef struct packed {
        logic signed [31:0] scale;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
    } t_side;

endpackage

// ===== sv/euler_scale_transform_matrix_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_scale_transform_matrix_unit
// Builds a scaled 4x4 affine matrix from roll, pitch, yaw, scale and shift.
// ----------------------------------------------------------------------------
// channel  | handshake                  | payload
// input    | i_in_valid / o_in_ready    | angles, scale, shifts
// result   | o_out_valid / i_out_ready  | row number, four elements, last
// config   | i_cfg_valid / o_cfg_ready  | angle factor
//
// Fourteen register stages; one item may enter each cycle while o_in_ready is
// high. Each item leaves as four rows, one per cycle while i_out_ready is high;
// the single result port sets the sustained rate. Row 0 comes from the row
// buffer, loaded from the last stage. A full buffer and valid last stage hold
// the pipeline; reset clears valid bits and row count, sets the factor to 256.
// ----------------------------------------------------------------------------
module euler_scale_transform_matrix_unit #(
    parameter int ANGLE_BITS = est_pkg::ANGLE_BITS_DEF,
    parameter int FRAC_BITS  = est_pkg::FRAC_BITS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [15:0]        i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [15:0]        i_roll_angle,
    input  logic [15:0]        i_pitch_angle,
    input  logic [15:0]        i_yaw_angle,
    input  logic signed [31:0] i_uniform_scale,
    input  logic signed [31:0] i_shift_x,
    input  logic signed [31:0] i_shift_y,
    input  logic signed [31:0] i_shift_z,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [1:0]         o_row_number,
    output logic signed [31:0] o_elem_a,
    output logic signed [31:0] o_elem_b,
    output logic signed [31:0] o_elem_c,
    output logic signed [31:0] o_elem_d,
    output logic               o_final_row
);

    localparam int AW   = ANGLE_BITS;
    localparam int LAST = 13;

    function automatic logic signed [31:0] mul30(
        input logic signed [31:0] a,
        input logic signed [31:0] b
    );
        logic signed [63:0] p;
        p = a * b;
        return p[61:30];
    endfunction

    logic               en;
    logic               out_free;
    logic               row_step;
    logic [15:0]        r_factor;
    logic [LAST:0]      r_vld;
    est_pkg::t_side     r_side [0:LAST];

    logic [AW-1:0]      r_ra, r_pa, r_ya;
    logic [30:0]        r_u    [1:7][0:5];
    logic [5:0]         r_neg  [1:7];
    logic [30:0]        r_u2   [2:6][0:5];
    logic signed [33:0] r_p    [3:7][0:5];
    logic signed [31:0] r_sin  [0:5];

    logic signed [31:0] r_srsp, r_crsp, r_cpcy, r_cpsy, r_srcp, r_crcp;
    logic signed [31:0] r_crsy, r_crcy, r_srsy, r_srcy, r_sp9, r_cy9, r_sy9;
    logic signed [31:0] r_srspcy, r_srspsy, r_crspcy, r_crspsy;
    logic signed [31:0] r_cpcy10, r_cpsy10, r_srcp10, r_crcp10;
    logic signed [31:0] r_crsy10, r_crcy10, r_srsy10, r_srcy10, r_sp10;
    logic signed [33:0] r_e    [0:8];
    logic signed [65:0] r_prod [0:8];
    logic signed [31:0] r_sat  [0:8];

    logic               r_ov;
    logic [1:0]         r_row;
    logic signed [31:0] r_mat  [0:8];
    est_pkg::t_side     r_osd;

    logic [AW+15:0]     pprod, yprod;
    logic [31:0]        turn   [0:5];
    logic [AW-1:0]      pa_s, ya_s;

    assign out_free    = !r_ov || (i_out_ready && r_row == est_pkg::ROW_LAST);
    assign en          = out_free || !r_vld[LAST];
    assign o_in_ready  = en;
    assign o_cfg_ready = 1'b1;
    assign row_step    = r_ov && i_out_ready && r_row != est_pkg::ROW_LAST
                         && !(en && r_vld[LAST]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_factor <= est_pkg::FACTOR_RST;
        end else if (i_cfg_valid) begin
            r_factor <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[LAST-1:0], i_in_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= '{i_uniform_scale, i_shift_x, i_shift_y, i_shift_z};
            for (int s = 1; s <= LAST; s++) begin
                r_side[s] <= r_side[s-1];
            end
        end
    end

    // stage 0: register the angles
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_ra <= AW'(i_roll_angle);
            r_pa <= AW'(i_pitch_angle);
            r_ya <= AW'(i_yaw_angle);
        end
    end

    // stage 1: scale pitch and yaw, fold each turn into a quarter
    always_comb begin
        pprod   = (AW+16)'(r_pa) * (AW+16)'(r_factor);
        yprod   = (AW+16)'(r_ya) * (AW+16)'(r_factor);
        pa_s    = pprod[AW+7:8];
        ya_s    = yprod[AW+7:8];
        turn[0] = 32'(r_ra) << (32 - AW);
        turn[2] = 32'(pa_s) << (32 - AW);
        turn[4] = 32'(ya_s) << (32 - AW);
        turn[1] = turn[0] + 32'h4000_0000;
        turn[3] = turn[2] + 32'h4000_0000;
        turn[5] = turn[4] + 32'h4000_0000;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int l = 0; l < 6; l++) begin
                r_u[1][l]  <= turn[l][30] ? (est_pkg::Q30_ONE - {1'b0, turn[l][29:0]})
                                          : {1'b0, turn[l][29:0]};
                r_neg[1][l] <= turn[l][31];
            end
            for (int s = 2; s <= 7; s++) begin
                r_u[s]   <= r_u[s-1];
                r_neg[s] <= r_neg[s-1];
            end
        end
    end

    // stage 2: square; stages 3 to 7: one Horner step each
    always_ff @(posedge i_clk) begin
        logic [61:0]        sq;
        logic signed [65:0] hp;
        if (en) begin
            for (int l = 0; l < 6; l++) begin
                sq         = 62'(r_u[1][l]) * 62'(r_u[1][l]);
                r_u2[2][l] <= sq[60:30];
                hp         = 66'(est_pkg::SIN_COEF[5]) * 66'(signed'({1'b0, r_u2[2][l]}));
                r_p[3][l]  <= est_pkg::SIN_COEF[4] - hp[63:30];
            end
            for (int s = 3; s <= 6; s++) begin
                r_u2[s] <= r_u2[s-1];
            end
            for (int s = 4; s <= 7; s++) begin
                for (int l = 0; l < 6; l++) begin
                    hp        = 66'(r_p[s-1][l]) * 66'(signed'({1'b0, r_u2[s-1][l]}));
                    r_p[s][l] <= est_pkg::SIN_COEF[7-s] - hp[63:30];
                end
            end
        end
    end

    // stage 8: final multiply, clamp and sign
    always_ff @(posedge i_clk) begin
        logic signed [65:0] fp;
        logic signed [35:0] fs;
        logic [30:0]        m;
        if (en) begin
            for (int l = 0; l < 6; l++) begin
                fp = 66'(r_p[7][l]) * 66'(signed'({1'b0, r_u[7][l]}));
                fs = fp[65:30];
                if (fs > 36'sd1073741824) begin
                    m = est_pkg::Q30_ONE;
                end else if (fs < 36'sd0) begin
                    m = '0;
                end else begin
                    m = fs[30:0];
                end
                r_sin[l] <= r_neg[7][l] ? -32'(m) : 32'(m);
            end
        end
    end

    // stage 9: first products (lanes: sr cr sp cp sy cy)
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_srsp <= mul30(r_sin[0], r_sin[2]);
            r_crsp <= mul30(r_sin[1], r_sin[2]);
            r_cpcy <= mul30(r_sin[3], r_sin[5]);
            r_cpsy <= mul30(r_sin[3], r_sin[4]);
            r_srcp <= mul30(r_sin[0], r_sin[3]);
            r_crcp <= mul30(r_sin[1], r_sin[3]);
            r_crsy <= mul30(r_sin[1], r_sin[4]);
            r_crcy <= mul30(r_sin[1], r_sin[5]);
            r_srsy <= mul30(r_sin[0], r_sin[4]);
            r_srcy <= mul30(r_sin[0], r_sin[5]);
            r_sp9  <= r_sin[2];
            r_cy9  <= r_sin[5];
            r_sy9  <= r_sin[4];
        end
    end

    // stage 10: second products
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_srspcy <= mul30(r_srsp, r_cy9);
            r_srspsy <= mul30(r_srsp, r_sy9);
            r_crspcy <= mul30(r_crsp, r_cy9);
            r_crspsy <= mul30(r_crsp, r_sy9);
            r_cpcy10 <= r_cpcy;
            r_cpsy10 <= r_cpsy;
            r_srcp10 <= r_srcp;
            r_crcp10 <= r_crcp;
            r_crsy10 <= r_crsy;
            r_crcy10 <= r_crcy;
            r_srsy10 <= r_srsy;
            r_srcy10 <= r_srcy;
            r_sp10   <= r_sp9;
        end
    end

    // stage 11: sums and differences; other elements are copied or negated
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_e[0] <= 34'(r_cpcy10);
            r_e[1] <= 34'(r_cpsy10);
            r_e[2] <= -34'(r_sp10);
            r_e[3] <= 34'(r_srspcy) - 34'(r_crsy10);
            r_e[4] <= 34'(r_srspsy) + 34'(r_crcy10);
            r_e[5] <= 34'(r_srcp10);
            r_e[6] <= 34'(r_crspcy) + 34'(r_srsy10);
            r_e[7] <= 34'(r_crspsy) - 34'(r_srcy10);
            r_e[8] <= 34'(r_crcp10);
        end
    end

    // stage 12: scale; stage 13: round and saturate
    always_ff @(posedge i_clk) begin
        logic signed [65:0] rp;
        logic signed [35:0] rs;
        if (en) begin
            for (int k = 0; k < 9; k++) begin
                r_prod[k] <= 66'(r_e[k]) * 66'(r_side[11].scale);
                rp = r_prod[k] + 66'sd536870912;
                rs = rp[65:30];
                if (rs > 36'sd2147483647) begin
                    r_sat[k] <= 32'sh7FFF_FFFF;
                end else if (rs < -36'sd2147483648) begin
                    r_sat[k] <= 32'sh8000_0000;
                end else begin
                    r_sat[k] <= rs[31:0];
                end
            end
        end
    end

    // row buffer: hold a matrix, advance one row per row taken by the receiver
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov  <= 1'b0;
            r_row <= '0;
        end else if (en && r_vld[LAST]) begin
            r_ov  <= 1'b1;
            r_row <= '0;
        end else if (r_ov && i_out_ready) begin
            if (r_row == est_pkg::ROW_LAST) begin
                r_ov <= 1'b0;
            end else begin
                r_row <= r_row + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && r_vld[LAST]) begin
            r_mat <= r_sat;
            r_osd <= r_side[LAST];
        end
    end

    always_comb begin
        o_out_valid  = r_ov;
        o_row_number = r_row;
        o_final_row  = (r_row == est_pkg::ROW_LAST);
        o_elem_d     = '0;
        case (r_row)
            2'd0: begin
                o_elem_a = r_mat[0];
                o_elem_b = r_mat[1];
                o_elem_c = r_mat[2];
            end
            2'd1: begin
                o_elem_a = r_mat[3];
                o_elem_b = r_mat[4];
                o_elem_c = r_mat[5];
            end
            2'd2: begin
                o_elem_a = r_mat[6];
                o_elem_b = r_mat[7];
                o_elem_c = r_mat[8];
            end
            default: begin
                o_elem_a = r_osd.sx;
                o_elem_b = r_osd.sy;
                o_elem_c = r_osd.sz;
                o_elem_d = 32'sd1 <<< FRAC_BITS;
            end
        endcase
    end

`include "assert_macros.svh"

    `EST_ASSERT_IMPL(a_stall_full, i_clk, i_rst_n, !o_in_ready, r_vld[LAST] && r_ov)
    `EST_ASSERT(a_load_row0, i_clk, i_rst_n, (en && r_vld[LAST]) |=> (r_ov && r_row == 2'd0))
    `EST_ASSERT(a_row_step, i_clk, i_rst_n, row_step |=> (r_ov && r_row == $past(r_row) + 2'd1))

endmodule

// ===== bench/tb_euler_scale_transform_matrix_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_euler_scale_transform_matrix_unit
// Drives angle, scale and shift items into the matrix unit, predicts the four
// rows of each affine matrix with a fixed-point sine model, and checks every
// row field by field under random gaps, stalls and angle factor changes.
// ----------------------------------------------------------------------------
module tb_euler_scale_transform_matrix_unit;

    typedef struct {
        logic [15:0]        roll;
        logic [15:0]        pitch;
        logic [15:0]        yaw;
        logic signed [31:0] scale;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
        logic signed [31:0] sz;
    } t_pose;

    typedef struct {
        logic [1:0]         row;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic signed [31:0] c;
        logic signed [31:0] d;
        logic               last;
    } t_row;

    localparam longint ONE30 = 64'sd1 << 30;
    localparam int LATENCY = 15;
    localparam longint CYCLE_LIMIT = 400000;

    logic               i_clk;
    logic               i_rst_n;
    logic               i_cfg_valid;
    logic               o_cfg_ready;
    logic [15:0]        i_cfg_data;
    logic               i_in_valid;
    logic               o_in_ready;
    logic [15:0]        i_roll_angle;
    logic [15:0]        i_pitch_angle;
    logic [15:0]        i_yaw_angle;
    logic signed [31:0] i_uniform_scale;
    logic signed [31:0] i_shift_x;
    logic signed [31:0] i_shift_y;
    logic signed [31:0] i_shift_z;
    logic               o_out_valid;
    logic               i_out_ready;
    logic [1:0]         o_row_number;
    logic signed [31:0] o_elem_a;
    logic signed [31:0] o_elem_b;
    logic signed [31:0] o_elem_c;
    logic signed [31:0] o_elem_d;
    logic               o_final_row;

    euler_scale_transform_matrix_unit DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid),
        .o_cfg_ready    (o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_roll_angle   (i_roll_angle),
        .i_pitch_angle  (i_pitch_angle),
        .i_yaw_angle    (i_yaw_angle),
        .i_uniform_scale(i_uniform_scale),
        .i_shift_x      (i_shift_x),
        .i_shift_y      (i_shift_y),
        .i_shift_z      (i_shift_z),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_row_number   (o_row_number),
        .o_elem_a       (o_elem_a),
        .o_elem_b       (o_elem_b),
        .o_elem_c       (o_elem_c),
        .o_elem_d       (o_elem_d),
        .o_final_row    (o_final_row)
    );

    t_pose       pose_q[$];
    t_row        row_q[$];
    logic [15:0] factor;
    int          mismatches;
    int          gap_left;
    int          stall_left;
    longint      cycles;

    function automatic longint floor_sh(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint fmul(longint x, longint y);
        return (x * y) >>> 30;
    endfunction

    function automatic longint quarter_sin(longint u);
        longint coef [0:5];
        longint u2;
        longint p;
        coef = '{64'sd1686629713, 64'sd693598670, 64'sd85569306,
                 64'sd5026995, 64'sd172271, 64'sd3864};
        u2 = (u * u) >>> 30;
        p = coef[5];
        for (int k = 4; k >= 0; k--) begin
            p = coef[k] - ((p * u2) >>> 30);
        end
        p = (p * u) >>> 30;
        if (p > ONE30) p = ONE30;
        if (p < 0) p = 0;
        return p;
    endfunction

    function automatic longint turn_sin(logic [31:0] t);
        longint f;
        longint m;
        f = longint'(t[29:0]);
        m = t[30] ? quarter_sin(ONE30 - f) : quarter_sin(f);
        return t[31] ? -m : m;
    endfunction

    function automatic logic signed [31:0] scale_sat(longint e, longint s);
        longint r;
        r = floor_sh(e * s + (64'sd1 << 29), 30);
        if (r > 64'sd2147483647) r = 64'sd2147483647;
        if (r < -64'sd2147483648) r = -64'sd2147483648;
        return r[31:0];
    endfunction

    task automatic predict_matrix(t_pose p);
        logic [31:0] pa;
        logic [31:0] ya;
        logic [31:0] tr;
        logic [31:0] tp;
        logic [31:0] ty;
        longint sr, cr, sp, cp, sy, cy, s, srsp, crsp;
        t_row r;
        pa = (32'(p.pitch) * 32'(factor)) >> 8;
        ya = (32'(p.yaw) * 32'(factor)) >> 8;
        tr = {p.roll, 16'h0};
        tp = {pa[15:0], 16'h0};
        ty = {ya[15:0], 16'h0};
        sr = turn_sin(tr); cr = turn_sin(tr + 32'h4000_0000);
        sp = turn_sin(tp); cp = turn_sin(tp + 32'h4000_0000);
        sy = turn_sin(ty); cy = turn_sin(ty + 32'h4000_0000);
        s = longint'(p.scale);
        srsp = fmul(sr, sp);
        crsp = fmul(cr, sp);
        r.d = 0;
        r.last = 1'b0;
        r.row = 2'd0;
        r.a = scale_sat(fmul(cp, cy), s);
        r.b = scale_sat(fmul(cp, sy), s);
        r.c = scale_sat(-sp, s);
        row_q.push_back(r);
        r.row = 2'd1;
        r.a = scale_sat(fmul(srsp, cy) - fmul(cr, sy), s);
        r.b = scale_sat(fmul(srsp, sy) + fmul(cr, cy), s);
        r.c = scale_sat(fmul(sr, cp), s);
        row_q.push_back(r);
        r.row = 2'd2;
        r.a = scale_sat(fmul(crsp, cy) + fmul(sr, sy), s);
        r.b = scale_sat(fmul(crsp, sy) - fmul(sr, cy), s);
        r.c = scale_sat(fmul(cr, cp), s);
        row_q.push_back(r);
        r.row = 2'd3;
        r.a = p.sx;
        r.b = p.sy;
        r.c = p.sz;
        r.d = 32'sd1 << 16;
        r.last = 1'b1;
        row_q.push_back(r);
    endtask

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 99);
        if (k < 50) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_q();
        case ($urandom_range(0, 5))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_pose rand_pose();
        t_pose p;
        p.roll = $urandom;
        p.pitch = $urandom;
        p.yaw = $urandom;
        p.scale = rand_q();
        p.sx = $urandom;
        p.sy = $urandom;
        p.sz = $urandom;
        return p;
    endfunction

    function automatic t_pose make_pose(logic [15:0] ro, logic [15:0] pi,
                                        logic [15:0] ya, logic [31:0] sc);
        t_pose p;
        p.roll = ro;
        p.pitch = pi;
        p.yaw = ya;
        p.scale = sc;
        p.sx = $urandom;
        p.sy = $urandom;
        p.sz = $urandom;
        return p;
    endfunction

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
            gap_left <= 0;
        end else if (i_in_valid && !o_in_ready) begin
            // hold
        end else if (i_in_valid || gap_left == 0) begin
            int g;
            g = 0;
            if (i_in_valid) begin
                predict_matrix(pose_q.pop_front());
                g = pick_gap();
            end
            gap_left <= g;
            if (g == 0 && pose_q.size() > 0) begin
                i_in_valid <= 1'b1;
                i_roll_angle <= pose_q[0].roll;
                i_pitch_angle <= pose_q[0].pitch;
                i_yaw_angle <= pose_q[0].yaw;
                i_uniform_scale <= pose_q[0].scale;
                i_shift_x <= pose_q[0].sx;
                i_shift_y <= pose_q[0].sy;
                i_shift_z <= pose_q[0].sz;
            end else begin
                i_in_valid <= 1'b0;
            end
        end else begin
            gap_left <= gap_left - 1;
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
            stall_left <= 0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (row_q.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("unexpected row %0d", o_row_number);
                end else begin
                    t_row e;
                    e = row_q.pop_front();
                    if (e.row !== o_row_number || e.a !== o_elem_a || e.b !== o_elem_b
                        || e.c !== o_elem_c || e.d !== o_elem_d
                        || e.last !== o_final_row) begin
                        mismatches++;
                        if (mismatches <= 10) begin
                            $display("row mismatch exp %0d %0d %0d %0d %0d %0d",
                                     e.row, e.a, e.b, e.c, e.d, e.last);
                            $display("             got %0d %0d %0d %0d %0d %0d",
                                     o_row_number, o_elem_a, o_elem_b, o_elem_c,
                                     o_elem_d, o_final_row);
                        end
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left <= stall_left - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                if ($urandom_range(0, 9) == 0) stall_left <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    task automatic wait_drained();
        while (pose_q.size() > 0 || i_in_valid || row_q.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (LATENCY + 5) @(posedge i_clk);
    endtask

    task automatic write_factor(logic [15:0] v);
        i_cfg_valid <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        factor = v;
    endtask

    initial begin
        logic [15:0] factors [0:5];
        factors = '{16'd0, 16'hFFFF, 16'd256, 16'd1, 16'd384, 16'h8000};
        mismatches = 0;
        cycles = 0;
        factor = 16'd256;
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_data = '0;
        i_in_valid = 1'b0;
        i_out_ready = 1'b0;
        i_roll_angle = '0;
        i_pitch_angle = '0;
        i_yaw_angle = '0;
        i_uniform_scale = '0;
        i_shift_x = '0;
        i_shift_y = '0;
        i_shift_z = '0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: quadrants, extremes, saturation, wrap at reset factor
        pose_q.push_back(make_pose(16'h0000, 16'h0000, 16'h0000, 32'h0001_0000));
        pose_q.push_back(make_pose(16'h4000, 16'h4000, 16'h4000, 32'h0001_0000));
        pose_q.push_back(make_pose(16'h8000, 16'h8000, 16'h8000, 32'hFFFF_0000));
        pose_q.push_back(make_pose(16'hC000, 16'hC000, 16'hC000, 32'h7FFF_FFFF));
        pose_q.push_back(make_pose(16'hFFFF, 16'hFFFF, 16'hFFFF, 32'h8000_0000));
        pose_q.push_back(make_pose(16'h2000, 16'h1000, 16'h6000, 32'h7FFF_FFFF));
        pose_q.push_back(make_pose(16'h5555, 16'hAAAA, 16'h1234, 32'h8000_0000));
        pose_q.push_back(make_pose(16'h0001, 16'h7FFF, 16'h8001, 32'h0000_0000));
        pose_q.push_back(make_pose(16'h3FFF, 16'hBFFF, 16'h4001, 32'h0000_0001));
        for (int i = 0; i < 10; i++) pose_q.push_back(rand_pose());
        wait_drained();

        // directed at large factor: wrap of scaled angles
        write_factor(16'hFFFF);
        pose_q.push_back(make_pose(16'h1000, 16'hFFFF, 16'h8000, 32'h0001_0000));
        pose_q.push_back(make_pose(16'h1000, 16'h4000, 16'h0101, 32'h7FFF_FFFF));
        for (int i = 0; i < 4; i++) pose_q.push_back(rand_pose());
        wait_drained();

        foreach (factors[f]) begin
            write_factor(f == 5 ? 16'($urandom) : factors[f]);
            for (int i = 0; i < 50; i++) pose_q.push_back(rand_pose());
            wait_drained();
        end

        if (mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
